@@ rtl/core/tscan_pkg.sv @@
// Shared constants, codes and types for the token scanner.
// Used by tscan_core, tscan_obuf and token_scanner; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tscan_pkg;

    localparam int POSITION_BITS_DEF = 20;
    localparam int LINE_BITS         = 20;
    localparam int KIND_BITS         = 5;
    localparam int ERR_BITS          = 2;
    localparam int MODE_BITS         = 4;
    localparam int MAX_RES           = 4;
    localparam int RES_IDX_BITS      = 2;
    localparam int COUNT_BITS        = 3;
    localparam int RES_BITS_DEF      = 2 * POSITION_BITS_DEF + LINE_BITS + KIND_BITS + ERR_BITS;

    localparam logic [LINE_BITS-1:0] LINE_MAX   = '1;
    localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

    // scanner modes
    localparam logic [MODE_BITS-1:0] M_START   = 4'd0;
    localparam logic [MODE_BITS-1:0] M_BANG    = 4'd1;
    localparam logic [MODE_BITS-1:0] M_EQUAL   = 4'd2;
    localparam logic [MODE_BITS-1:0] M_LESS    = 4'd3;
    localparam logic [MODE_BITS-1:0] M_GREATER = 4'd4;
    localparam logic [MODE_BITS-1:0] M_SLASH   = 4'd5;
    localparam logic [MODE_BITS-1:0] M_COMMENT = 4'd6;
    localparam logic [MODE_BITS-1:0] M_INT     = 4'd7;
    localparam logic [MODE_BITS-1:0] M_DOT     = 4'd8;
    localparam logic [MODE_BITS-1:0] M_FRAC    = 4'd9;
    localparam logic [MODE_BITS-1:0] M_IDENT   = 4'd10;
    localparam logic [MODE_BITS-1:0] M_STRING  = 4'd11;
    localparam logic [MODE_BITS-1:0] M_DISCARD = 4'd12;

    // token kinds
    localparam logic [KIND_BITS-1:0] K_LPAREN     = 5'd0;
    localparam logic [KIND_BITS-1:0] K_RPAREN     = 5'd1;
    localparam logic [KIND_BITS-1:0] K_LBRACE     = 5'd2;
    localparam logic [KIND_BITS-1:0] K_RBRACE     = 5'd3;
    localparam logic [KIND_BITS-1:0] K_LBRACKET   = 5'd4;
    localparam logic [KIND_BITS-1:0] K_RBRACKET   = 5'd5;
    localparam logic [KIND_BITS-1:0] K_COMMA      = 5'd6;
    localparam logic [KIND_BITS-1:0] K_DOT        = 5'd7;
    localparam logic [KIND_BITS-1:0] K_MINUS      = 5'd8;
    localparam logic [KIND_BITS-1:0] K_PLUS       = 5'd9;
    localparam logic [KIND_BITS-1:0] K_SEMICOLON  = 5'd10;
    localparam logic [KIND_BITS-1:0] K_STAR       = 5'd11;
    localparam logic [KIND_BITS-1:0] K_BANG       = 5'd12;
    localparam logic [KIND_BITS-1:0] K_BANG_EQ    = 5'd13;
    localparam logic [KIND_BITS-1:0] K_EQUAL      = 5'd14;
    localparam logic [KIND_BITS-1:0] K_EQUAL_EQ   = 5'd15;
    localparam logic [KIND_BITS-1:0] K_LESS       = 5'd16;
    localparam logic [KIND_BITS-1:0] K_LESS_EQ    = 5'd17;
    localparam logic [KIND_BITS-1:0] K_GREATER    = 5'd18;
    localparam logic [KIND_BITS-1:0] K_GREATER_EQ = 5'd19;
    localparam logic [KIND_BITS-1:0] K_SLASH      = 5'd20;
    localparam logic [KIND_BITS-1:0] K_STRING     = 5'd21;
    localparam logic [KIND_BITS-1:0] K_NUMBER     = 5'd22;
    localparam logic [KIND_BITS-1:0] K_IDENT      = 5'd23;
    localparam logic [KIND_BITS-1:0] K_END        = 5'd24;

    // error codes
    localparam logic [ERR_BITS-1:0] E_NONE      = 2'd0;
    localparam logic [ERR_BITS-1:0] E_UNEXPECT  = 2'd1;
    localparam logic [ERR_BITS-1:0] E_UNTERM    = 2'd2;

    // characters
    localparam logic [7:0] C_TAB      = 8'h09;
    localparam logic [7:0] C_NEWLINE  = 8'h0A;
    localparam logic [7:0] C_CR       = 8'h0D;
    localparam logic [7:0] C_SPACE    = 8'h20;
    localparam logic [7:0] C_BANG     = 8'h21;
    localparam logic [7:0] C_QUOTE    = 8'h22;
    localparam logic [7:0] C_LPAREN   = 8'h28;
    localparam logic [7:0] C_RPAREN   = 8'h29;
    localparam logic [7:0] C_STAR     = 8'h2A;
    localparam logic [7:0] C_PLUS     = 8'h2B;
    localparam logic [7:0] C_COMMA    = 8'h2C;
    localparam logic [7:0] C_MINUS    = 8'h2D;
    localparam logic [7:0] C_DOT      = 8'h2E;
    localparam logic [7:0] C_SLASH    = 8'h2F;
    localparam logic [7:0] C_ZERO     = 8'h30;
    localparam logic [7:0] C_NINE     = 8'h39;
    localparam logic [7:0] C_SEMI     = 8'h3B;
    localparam logic [7:0] C_LESS     = 8'h3C;
    localparam logic [7:0] C_EQUAL    = 8'h3D;
    localparam logic [7:0] C_GREATER  = 8'h3E;
    localparam logic [7:0] C_UPPER_A  = 8'h41;
    localparam logic [7:0] C_UPPER_Z  = 8'h5A;
    localparam logic [7:0] C_LBRACKET = 8'h5B;
    localparam logic [7:0] C_RBRACKET = 8'h5D;
    localparam logic [7:0] C_UNDER    = 8'h5F;
    localparam logic [7:0] C_LOWER_A  = 8'h61;
    localparam logic [7:0] C_LOWER_Z  = 8'h7A;
    localparam logic [7:0] C_LBRACE   = 8'h7B;
    localparam logic [7:0] C_RBRACE   = 8'h7D;

    // handoff from scan core to result buffer
    typedef struct packed {
        logic                  valid;
        logic [COUNT_BITS-1:0] count;
    } t_push;

    typedef struct packed {
        logic                 hit;
        logic [KIND_BITS-1:0] kind;
    } t_punct;

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[C_ZERO:C_NINE]});
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[C_LOWER_A:C_LOWER_Z], [C_UPPER_A:C_UPPER_Z], C_UNDER});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {[C_TAB:C_CR], C_SPACE});
    endfunction

    function automatic t_punct punct_kind(input logic [7:0] c);
        t_punct p;
        p.hit  = 1'b1;
        p.kind = K_LPAREN;
        case (c)
            C_LPAREN:   p.kind = K_LPAREN;
            C_RPAREN:   p.kind = K_RPAREN;
            C_LBRACE:   p.kind = K_LBRACE;
            C_RBRACE:   p.kind = K_RBRACE;
            C_LBRACKET: p.kind = K_LBRACKET;
            C_RBRACKET: p.kind = K_RBRACKET;
            C_COMMA:    p.kind = K_COMMA;
            C_DOT:      p.kind = K_DOT;
            C_MINUS:    p.kind = K_MINUS;
            C_PLUS:     p.kind = K_PLUS;
            C_SEMI:     p.kind = K_SEMICOLON;
            C_STAR:     p.kind = K_STAR;
            default:    p.hit  = 1'b0;
        endcase
        return p;
    endfunction

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] line);
        return (line == LINE_MAX) ? line : line + LINE_BITS'(1);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/tscan_obuf.sv @@
// Result buffer: holds one byte's tokens, drains a beat per cycle while i_ready is high.
// Depends on tscan_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tscan_obuf #(
    parameter int DATA_BITS = tscan_pkg::RES_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  tscan_pkg::t_push       i_push,
    input  wire  [tscan_pkg::MAX_RES-1:0][DATA_BITS-1:0] i_data,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic [DATA_BITS-1:0]   o_data,
    output logic                   o_last
);

    logic [tscan_pkg::MAX_RES-1:0][DATA_BITS-1:0] r_data;
    logic [tscan_pkg::COUNT_BITS-1:0]             r_cnt;
    logic [tscan_pkg::RES_IDX_BITS-1:0]           r_idx;
    logic                                         pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_data[r_idx];
    assign o_last  = ({1'b0, r_idx} == (r_cnt - tscan_pkg::COUNT_BITS'(1)));
    assign pop     = o_valid && i_ready;
    // free when empty or the final beat of the run leaves this cycle
    assign o_free  = !o_valid || (pop && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_push.valid) begin
            r_cnt <= i_push.count;
            r_idx <= '0;
        end else if (pop) begin
            if (o_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + tscan_pkg::RES_IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_data <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tscan_core.sv @@
// Scan core: input register, scanner state and the per-byte token logic.
// Depends on tscan_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tscan_core #(
    parameter  int POSITION_BITS = tscan_pkg::POSITION_BITS_DEF,
    localparam int RW = 2 * POSITION_BITS + tscan_pkg::LINE_BITS
                        + tscan_pkg::KIND_BITS + tscan_pkg::ERR_BITS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_char,
    input  wire                 i_last,
    input  wire                 i_buf_free,
    output tscan_pkg::t_push    o_push,
    output logic [tscan_pkg::MAX_RES-1:0][RW-1:0] o_res
);

    localparam int PB = POSITION_BITS;
    localparam int LB = tscan_pkg::LINE_BITS;
    localparam logic [PB-1:0] POS_MAX = '1;
    localparam logic [PB-1:0] POS_ONE = PB'(1);

    // field order from the top: error, kind, line, length, start
    typedef struct packed {
        logic [tscan_pkg::ERR_BITS-1:0]  err;
        logic [tscan_pkg::KIND_BITS-1:0] kind;
        logic [LB-1:0]                   line;
        logic [PB-1:0]                   len;
        logic [PB-1:0]                   start;
    } t_res;

    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_flush;

    typedef struct packed {
        logic [tscan_pkg::MODE_BITS-1:0] mode;
        logic                            set_tb;
        logic [LB-1:0]                   line;
        logic                            hit;
        t_res                            r;
    } t_start;

    function automatic t_res mk(input logic [tscan_pkg::KIND_BITS-1:0] kind,
                                input logic [PB-1:0] st, input logic [PB-1:0] len,
                                input logic [LB-1:0] line,
                                input logic [tscan_pkg::ERR_BITS-1:0] err);
        t_res r;
        r.err   = err;
        r.kind  = kind;
        r.line  = line;
        r.len   = len;
        r.start = st;
        return r;
    endfunction

    function automatic logic [tscan_pkg::KIND_BITS-1:0] op_kind(
            input logic [tscan_pkg::MODE_BITS-1:0] mode);
        logic [tscan_pkg::KIND_BITS-1:0] k;
        case (mode)
            tscan_pkg::M_BANG:    k = tscan_pkg::K_BANG;
            tscan_pkg::M_EQUAL:   k = tscan_pkg::K_EQUAL;
            tscan_pkg::M_LESS:    k = tscan_pkg::K_LESS;
            tscan_pkg::M_GREATER: k = tscan_pkg::K_GREATER;
            default:              k = tscan_pkg::K_BANG;
        endcase
        return k;
    endfunction

    // emit whatever token is pending, ending at end_p
    function automatic t_flush flush_tok(input logic [tscan_pkg::MODE_BITS-1:0] mode,
                                         input logic [PB-1:0] tb,
                                         input logic [PB-1:0] end_p,
                                         input logic [LB-1:0] line);
        t_flush        f;
        logic [PB-1:0] len;
        logic [PB-1:0] dotpos;
        f      = '0;
        len    = (end_p >= tb) ? end_p - tb : '0;
        dotpos = (end_p > tb) ? end_p - POS_ONE : tb;
        case (mode)
            tscan_pkg::M_BANG, tscan_pkg::M_EQUAL, tscan_pkg::M_LESS,
            tscan_pkg::M_GREATER: begin
                f.n  = 2'd1;
                f.r0 = mk(op_kind(mode), tb, POS_ONE, line, tscan_pkg::E_NONE);
            end
            tscan_pkg::M_SLASH: begin
                f.n  = 2'd1;
                f.r0 = mk(tscan_pkg::K_SLASH, tb, POS_ONE, line, tscan_pkg::E_NONE);
            end
            tscan_pkg::M_INT, tscan_pkg::M_FRAC: begin
                f.n  = 2'd1;
                f.r0 = mk(tscan_pkg::K_NUMBER, tb, len, line, tscan_pkg::E_NONE);
            end
            tscan_pkg::M_DOT: begin
                // "digits." with no digit after: number, then the dot alone
                f.n  = 2'd2;
                f.r0 = mk(tscan_pkg::K_NUMBER, tb, dotpos - tb, line, tscan_pkg::E_NONE);
                f.r1 = mk(tscan_pkg::K_DOT, dotpos, POS_ONE, line, tscan_pkg::E_NONE);
            end
            tscan_pkg::M_IDENT: begin
                f.n  = 2'd1;
                f.r0 = mk(tscan_pkg::K_IDENT, tb, len, line, tscan_pkg::E_NONE);
            end
            tscan_pkg::M_STRING: begin
                f.n  = 2'd1;
                f.r0 = mk(tscan_pkg::K_LPAREN, tb, len, line, tscan_pkg::E_UNTERM);
            end
            default: f.n = 2'd0;
        endcase
        return f;
    endfunction

    // scan a byte at the start of a token
    function automatic t_start start_tok(input logic [7:0] c, input logic [PB-1:0] cur,
                                         input logic [LB-1:0] line);
        t_start            s;
        tscan_pkg::t_punct p;
        s      = '0;
        s.mode = tscan_pkg::M_START;
        s.line = line;
        p      = tscan_pkg::punct_kind(c);
        if (tscan_pkg::is_space(c)) begin
            if (c == tscan_pkg::C_NEWLINE) begin
                s.line = tscan_pkg::line_inc(line);
            end
        end else begin
            s.set_tb = 1'b1;
            if (tscan_pkg::is_digit(c)) begin
                s.mode = tscan_pkg::M_INT;
            end else if (tscan_pkg::is_alpha(c)) begin
                s.mode = tscan_pkg::M_IDENT;
            end else if (p.hit) begin
                s.hit = 1'b1;
                s.r   = mk(p.kind, cur, POS_ONE, line, tscan_pkg::E_NONE);
            end else begin
                case (c)
                    tscan_pkg::C_BANG:    s.mode = tscan_pkg::M_BANG;
                    tscan_pkg::C_EQUAL:   s.mode = tscan_pkg::M_EQUAL;
                    tscan_pkg::C_LESS:    s.mode = tscan_pkg::M_LESS;
                    tscan_pkg::C_GREATER: s.mode = tscan_pkg::M_GREATER;
                    tscan_pkg::C_SLASH:   s.mode = tscan_pkg::M_SLASH;
                    tscan_pkg::C_QUOTE:   s.mode = tscan_pkg::M_STRING;
                    default: begin
                        s.hit  = 1'b1;
                        s.r    = mk(tscan_pkg::K_LPAREN, cur, POS_ONE, line,
                                    tscan_pkg::E_UNEXPECT);
                        s.mode = tscan_pkg::M_DISCARD;
                    end
                endcase
            end
        end
        return s;
    endfunction

    logic                            r_valid;
    logic [7:0]                      r_char;
    logic                            r_last;
    logic [tscan_pkg::MODE_BITS-1:0] r_mode, n_mode;
    logic [PB-1:0]                   r_pos, n_pos;
    logic [PB-1:0]                   r_beg, n_beg;
    logic [LB-1:0]                   r_line, n_line;
    t_res [tscan_pkg::MAX_RES-1:0]   n_res;
    logic [tscan_pkg::COUNT_BITS-1:0] n_count;
    logic                            commit;

    always_comb begin
        t_flush        f1;
        t_flush        f2;
        t_start        st;
        logic [PB-1:0] cur;
        logic [PB-1:0] nxt;
        logic          do_flush;
        logic          do_start;

        cur      = r_pos;
        nxt      = (r_pos == POS_MAX) ? r_pos : r_pos + POS_ONE;
        n_mode   = r_mode;
        n_beg    = r_beg;
        n_line   = r_line;
        n_res    = '0;
        n_count  = '0;
        do_flush = 1'b0;
        do_start = 1'b0;
        f1       = '0;
        f2       = '0;
        st       = '0;

        case (r_mode)
            tscan_pkg::M_START: do_start = 1'b1;
            tscan_pkg::M_BANG, tscan_pkg::M_EQUAL, tscan_pkg::M_LESS,
            tscan_pkg::M_GREATER: begin
                if (r_char == tscan_pkg::C_EQUAL) begin
                    n_res[0] = mk(op_kind(r_mode) + tscan_pkg::KIND_BITS'(1), r_beg,
                                  nxt - r_beg, r_line, tscan_pkg::E_NONE);
                    n_count  = tscan_pkg::COUNT_BITS'(1);
                    n_mode   = tscan_pkg::M_START;
                end else begin
                    do_flush = 1'b1;
                    do_start = 1'b1;
                end
            end
            tscan_pkg::M_SLASH: begin
                if (r_char == tscan_pkg::C_SLASH) begin
                    n_mode = tscan_pkg::M_COMMENT;
                end else begin
                    do_flush = 1'b1;
                    do_start = 1'b1;
                end
            end
            tscan_pkg::M_COMMENT: do_start = (r_char == tscan_pkg::C_NEWLINE);
            tscan_pkg::M_INT: begin
                if (r_char == tscan_pkg::C_DOT) begin
                    n_mode = tscan_pkg::M_DOT;
                end else if (!tscan_pkg::is_digit(r_char)) begin
                    do_flush = 1'b1;
                    do_start = 1'b1;
                end
            end
            tscan_pkg::M_DOT: begin
                if (tscan_pkg::is_digit(r_char)) begin
                    n_mode = tscan_pkg::M_FRAC;
                end else begin
                    do_flush = 1'b1;
                    do_start = 1'b1;
                end
            end
            tscan_pkg::M_FRAC: begin
                do_flush = !tscan_pkg::is_digit(r_char);
                do_start = do_flush;
            end
            tscan_pkg::M_IDENT: begin
                do_flush = !(tscan_pkg::is_digit(r_char) || tscan_pkg::is_alpha(r_char));
                do_start = do_flush;
            end
            tscan_pkg::M_STRING: begin
                if (r_char == tscan_pkg::C_QUOTE) begin
                    n_res[0] = mk(tscan_pkg::K_STRING, r_beg, nxt - r_beg, r_line,
                                  tscan_pkg::E_NONE);
                    n_count  = tscan_pkg::COUNT_BITS'(1);
                    n_mode   = tscan_pkg::M_START;
                end else if (r_char == tscan_pkg::C_NEWLINE) begin
                    n_line = tscan_pkg::line_inc(r_line);
                end
            end
            tscan_pkg::M_DISCARD: n_mode = r_mode;
            default: do_start = 1'b1;
        endcase

        if (do_flush) begin
            f1 = flush_tok(n_mode, n_beg, cur, n_line);
            if (f1.n != 2'd0) begin
                n_res[n_count[tscan_pkg::RES_IDX_BITS-1:0]] = f1.r0;
                n_count = n_count + tscan_pkg::COUNT_BITS'(1);
            end
            if (f1.n == 2'd2) begin
                n_res[n_count[tscan_pkg::RES_IDX_BITS-1:0]] = f1.r1;
                n_count = n_count + tscan_pkg::COUNT_BITS'(1);
            end
            n_mode = tscan_pkg::M_START;
        end

        if (do_start) begin
            st     = start_tok(r_char, cur, n_line);
            n_mode = st.mode;
            n_line = st.line;
            if (st.set_tb) begin
                n_beg = cur;
            end
            if (st.hit) begin
                n_res[n_count[tscan_pkg::RES_IDX_BITS-1:0]] = st.r;
                n_count = n_count + tscan_pkg::COUNT_BITS'(1);
            end
        end

        n_pos = nxt;

        // final byte: flush at the end offset, add the end token, back to reset state
        if (r_last) begin
            f2 = flush_tok(n_mode, n_beg, nxt, n_line);
            if (f2.n != 2'd0) begin
                n_res[n_count[tscan_pkg::RES_IDX_BITS-1:0]] = f2.r0;
                n_count = n_count + tscan_pkg::COUNT_BITS'(1);
            end
            if (f2.n == 2'd2) begin
                n_res[n_count[tscan_pkg::RES_IDX_BITS-1:0]] = f2.r1;
                n_count = n_count + tscan_pkg::COUNT_BITS'(1);
            end
            n_res[n_count[tscan_pkg::RES_IDX_BITS-1:0]] =
                mk(tscan_pkg::K_END, nxt, '0, '0, tscan_pkg::E_NONE);
            n_count = n_count + tscan_pkg::COUNT_BITS'(1);
            n_mode  = tscan_pkg::M_START;
            n_pos   = '0;
            n_beg   = '0;
            n_line  = tscan_pkg::LINE_FIRST;
        end
    end

    // a byte with no tokens retires even while the buffer is busy
    assign commit  = r_valid && (i_buf_free || (n_count == '0));
    assign o_ready = !r_valid || commit;

    assign o_push.valid = commit && (n_count != '0);
    assign o_push.count = n_count;
    assign o_res        = n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= tscan_pkg::M_START;
            r_pos   <= '0;
            r_beg   <= '0;
            r_line  <= tscan_pkg::LINE_FIRST;
        end else begin
            if (commit) begin
                r_mode <= n_mode;
                r_pos  <= n_pos;
                r_beg  <= n_beg;
                r_line <= n_line;
            end
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
            end else if (commit) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char;
            r_last <= i_last;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/token_scanner.sv @@
// Token scanner top level: input stream of source bytes, output stream of tokens.
// Depends on tscan_pkg, tscan_core and tscan_obuf.
//
// Takes one source byte per beat and emits tokens (kind, start offset, length,
// line, error). A byte is taken every cycle as long as it causes at most one
// token and m_axis_tready is high; a byte that causes more (up to four, e.g. a
// flushed "12." plus a punctuation mark plus the end token) holds back the next
// token-producing byte until the four-entry result buffer, which drains one beat
// per cycle while m_axis_tready is high, has emitted them. Keywords come out as
// identifiers, positions saturate at 2^POSITION_BITS-1 and the line count at
// 2^20-1. After an error, bytes are dropped until the one marked by tlast; every
// tlast beat ends with an end token and returns the scanner to its reset state.
`timescale 1ns / 1ps
`default_nettype none
module token_scanner #(
    parameter  int POSITION_BITS = tscan_pkg::POSITION_BITS_DEF,
    localparam int PAY_BITS  = 2 * POSITION_BITS + tscan_pkg::LINE_BITS,
    localparam int DATA_BITS = ((PAY_BITS + 7) / 8) * 8,
    localparam int USER_BITS = tscan_pkg::KIND_BITS + tscan_pkg::ERR_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [7:0]           s_axis_tdata,  // [7:0] char_code
    input  wire                  s_axis_tlast,  // is_last
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [DATA_BITS-1:0] m_axis_tdata,  // token_start, token_length, line_number, zero fill
    output logic [USER_BITS-1:0] m_axis_tuser,  // token_kind, error_code
    output logic                 m_axis_tlast   // last_of_run
);

    localparam int RW = PAY_BITS + USER_BITS;

    tscan_pkg::t_push                      push;
    logic [tscan_pkg::MAX_RES-1:0][RW-1:0] res;
    logic                                  buf_free;
    logic [RW-1:0]                         buf_data;

    tscan_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_char     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_buf_free (buf_free),
        .o_push     (push),
        .o_res      (res)
    );

    tscan_obuf #(
        .DATA_BITS (RW)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_free  (buf_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (buf_data),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = DATA_BITS'(buf_data[PAY_BITS-1:0]);
    assign m_axis_tuser = buf_data[RW-1:PAY_BITS];

endmodule
`default_nettype wire
